### sv/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types and constants shared by the I2C master bit sequencer files.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

    localparam int BIT_COUNT = 8;

    // Sequence lengths in pin steps
    localparam logic [4:0] LEN_START = 5'd4;
    localparam logic [4:0] LEN_STOP  = 5'd3;
    localparam logic [4:0] LEN_WRITE = 5'(BIT_COUNT * 3 + 2);
    localparam logic [4:0] LEN_READ  = 5'(BIT_COUNT * 2 + 1);
    localparam logic [4:0] LEN_SACK  = 5'd3;
    localparam logic [4:0] LEN_RACK  = 5'd3;

    localparam logic [7:0] MSB_MASK = 8'h80;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_SACK  = 3'd5,
        OP_RACK  = 3'd6
    } t_op;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       ack_to_send;
        logic       sda_level;
    } t_in;

    typedef struct packed {
        logic       scl_drive;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_seen;
    } t_out;

    typedef struct packed {
        t_op        active_op;
        logic [4:0] step_index;
        logic [7:0] tx_shift;
        logic [7:0] rx_shift;
        logic       ack_latch;
        logic       scl;
        logic       sda;
    } t_state;

endpackage

`default_nettype wire

### sv/i2cms_step.sv
// ----------------------------------------------------------------------------
// i2cms_step
// One pin step: next sequencer state and the result for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_step (
    input  var i2cms_pkg::t_state i_state,
    input  var i2cms_pkg::t_in    i_data,
    output i2cms_pkg::t_state     o_state,
    output i2cms_pkg::t_out       o_result
);

    always_comb begin
        i2cms_pkg::t_state st;
        logic [4:0] len;
        logic [4:0] s;
        logic [8:0] prod;
        logic [3:0] quot;
        logic [4:0] phase;
        logic [2:0] bit_idx;
        logic [4:0] s_next;
        logic       busy;
        logic       done;

        st      = i_state;
        busy    = 1'b0;
        done    = 1'b0;
        len     = 5'd0;
        prod    = 9'd0;
        quot    = 4'd0;
        phase   = 5'd0;
        bit_idx = 3'd0;
        s_next  = 5'd0;

        // Launch a command only from idle; code 7 counts as none
        if (st.active_op == i2cms_pkg::OP_NONE &&
            i_data.func inside {[i2cms_pkg::OP_START:i2cms_pkg::OP_RACK]}) begin
            st.active_op  = i2cms_pkg::t_op'(i_data.func);
            st.step_index = 5'd0;
            if (st.active_op == i2cms_pkg::OP_WRITE) st.tx_shift = i_data.tx_byte;
            if (st.active_op == i2cms_pkg::OP_READ)  st.rx_shift = 8'd0;
            if (st.active_op == i2cms_pkg::OP_SACK)  st.sda      = i_data.ack_to_send;
        end

        s = st.step_index;
        // s / 3 as (s * 11) >> 5, exact for 5-bit s
        prod  = {4'd0, s} * 9'd11;
        quot  = prod[8:5];
        phase = s - 5'({quot, 1'b0} + {1'b0, quot});
        bit_idx = 3'((s - 5'd1) >> 1);

        case (st.active_op)
            i2cms_pkg::OP_START: len = i2cms_pkg::LEN_START;
            i2cms_pkg::OP_STOP:  len = i2cms_pkg::LEN_STOP;
            i2cms_pkg::OP_WRITE: len = i2cms_pkg::LEN_WRITE;
            i2cms_pkg::OP_READ:  len = i2cms_pkg::LEN_READ;
            i2cms_pkg::OP_SACK:  len = i2cms_pkg::LEN_SACK;
            i2cms_pkg::OP_RACK:  len = i2cms_pkg::LEN_RACK;
            default:             len = 5'd0;
        endcase

        case (st.active_op)
            i2cms_pkg::OP_START: begin
                if (s == 5'd0)      st.sda = 1'b1;
                else if (s == 5'd1) st.scl = 1'b1;
                else if (s == 5'd2) st.sda = 1'b0;
                else                st.scl = 1'b0;
            end
            i2cms_pkg::OP_STOP: begin
                if (s == 5'd0)      st.sda = 1'b0;
                else if (s == 5'd1) st.scl = 1'b1;
                else                st.sda = 1'b1;
            end
            i2cms_pkg::OP_WRITE: begin
                if (s < 5'(i2cms_pkg::BIT_COUNT * 3)) begin
                    if (phase == 5'd0) begin
                        st.sda = st.tx_shift[7];
                    end else if (phase == 5'd1) begin
                        st.scl = 1'b1;
                    end else begin
                        st.scl      = 1'b0;
                        st.tx_shift = {st.tx_shift[6:0], 1'b0};
                    end
                end else if (s == 5'(i2cms_pkg::BIT_COUNT * 3)) begin
                    st.scl = 1'b1;     // SCL high for the ack bit, ack not sampled
                end else begin
                    st.scl = 1'b0;
                end
            end
            i2cms_pkg::OP_READ: begin
                if (s == 5'd0) begin
                    st.sda = 1'b1;
                end else if (s[0]) begin
                    st.scl = 1'b1;
                    if (i_data.sda_level)
                        st.rx_shift = st.rx_shift | (i2cms_pkg::MSB_MASK >> bit_idx);
                end else begin
                    st.scl = 1'b0;
                end
            end
            i2cms_pkg::OP_SACK: begin
                if (s == 5'd1)      st.scl = 1'b1;
                else if (s == 5'd2) st.scl = 1'b0;
            end
            i2cms_pkg::OP_RACK: begin
                if (s == 5'd0) begin
                    st.sda = 1'b1;
                end else if (s == 5'd1) begin
                    st.scl       = 1'b1;
                    st.ack_latch = i_data.sda_level;
                end else begin
                    st.scl = 1'b0;
                end
            end
            default: ;
        endcase

        if (st.active_op != i2cms_pkg::OP_NONE) begin
            busy   = 1'b1;
            s_next = s + 5'd1;
            if (s_next >= len) begin
                done          = 1'b1;
                st.active_op  = i2cms_pkg::OP_NONE;
                st.step_index = 5'd0;
            end else begin
                st.step_index = s_next;
            end
        end

        o_state            = st;
        o_result.scl_drive = st.scl;
        o_result.sda_drive = st.sda;
        o_result.busy_res  = busy;
        o_result.done_res  = done;
        o_result.rx_byte   = st.rx_shift;
        o_result.ack_seen  = st.ack_latch;
    end

endmodule

`default_nettype wire

### sv/i2c_master_bit_sequencer_core.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_core
// Bit-level I2C master: each tick transaction advances one SCL/SDA pin step.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_in: command)
//   out     | output    | o_out_valid / i_out_stall| o_out_data (t_out: pins)
//
// Cycles: one tick per clock unless the output is stalled. The step logic
//   sits between the sequencer state register and the result register, so
//   each accepted tick's result is registered before it is shown.
// Reset: i_rst_n low at a clock edge clears the sequencer to idle with both
//   pins released high, and empties the result register.
// Stalls: the result register is the only buffer. The input stalls only when
//   a result is held and the downstream side stalls too.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer_core (
    input  var logic            i_clk,
    input  var logic            i_rst_n,
    input  var logic            i_in_valid,
    input  var i2cms_pkg::t_in  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output i2cms_pkg::t_out     o_out_data,
    input  var logic            i_out_stall
);

    i2cms_pkg::t_state r_state;
    i2cms_pkg::t_state n_state;
    i2cms_pkg::t_out   n_result;
    i2cms_pkg::t_out   r_out;
    logic              r_out_valid;
    logic              in_take;

    // Room for a new result when empty or when the held one leaves now
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_take    = i_in_valid & ~o_in_stall;

    i2cms_step u_step (
        .i_state  (r_state),
        .i_data   (i_in_data),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.active_op  <= i2cms_pkg::OP_NONE;
            r_state.step_index <= 5'd0;
            r_state.tx_shift   <= 8'd0;
            r_state.rx_shift   <= 8'd0;
            r_state.ack_latch  <= 1'b0;
            r_state.scl        <= 1'b1;
            r_state.sda        <= 1'b1;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload holds while stalled since in_take is low then
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks i2c_master_bit_sequencer_core tick by tick. A behavioral model of
// the sequencer predicts the pin levels and status of every accepted tick.
// The results are checked in order, with random idling and output stalls.
// ----------------------------------------------------------------------------

module testbench;

    localparam int BYTE_BITS    = 8;
    localparam int ITEM_TARGET  = 600;
    // ticks left over for the full-rate tail
    localparam int ITEM_RESERVE = 290;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 8;

    // Pin steps per command
    localparam logic [4:0] STEPS_START = 5'd4;
    localparam logic [4:0] STEPS_STOP  = 5'd3;
    localparam logic [4:0] STEPS_WRITE = 5'(BYTE_BITS * 3 + 2);
    localparam logic [4:0] STEPS_READ  = 5'(BYTE_BITS * 2 + 1);
    localparam logic [4:0] STEPS_ACK   = 5'd3;

    // Where the sampled SDA level comes from while a command runs
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RAND = 2;

    localparam logic [2:0] CODE_UNUSED = 3'd7;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    i2cms_pkg::t_in  i_in_data   = '0;
    logic            i_out_stall = 1'b0;
    logic            o_in_stall;
    logic            o_out_valid;
    i2cms_pkg::t_out o_out_data;

    // Model state of the sequencer
    i2cms_pkg::t_op cur_op   = i2cms_pkg::OP_NONE;
    logic [4:0]     cur_step = '0;
    logic [7:0]     tx_sr    = '0;
    logic [7:0]     rx_sr    = '0;
    logic           ack_lat  = 1'b0;
    logic           scl_lvl  = 1'b1;
    logic           sda_lvl  = 1'b1;

    i2cms_pkg::t_out expected_pins[$];
    int   mismatches  = 0;
    int   ticks_sent  = 0;
    int   cycle_count = 0;
    int   stall_left  = 0;
    logic allow_gaps  = 1'b1;

    i2c_master_bit_sequencer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Sequencer model: one call per accepted tick, returns the pin state.
    // ------------------------------------------------------------------------
    function automatic i2cms_pkg::t_out predict_tick(input i2cms_pkg::t_in tick);
        i2cms_pkg::t_out res;
        logic [4:0]      seq_len;
        int              bit_idx;
        res     = '0;
        seq_len = '0;
        // an idle sequencer latches a new command; a busy one ignores it
        if (cur_op == i2cms_pkg::OP_NONE && tick.func >= i2cms_pkg::OP_START &&
            tick.func <= i2cms_pkg::OP_RACK) begin
            cur_op   = i2cms_pkg::t_op'(tick.func);
            cur_step = '0;
            if (cur_op == i2cms_pkg::OP_WRITE) tx_sr = tick.tx_byte;
            if (cur_op == i2cms_pkg::OP_READ) rx_sr = '0;
            if (cur_op == i2cms_pkg::OP_SACK) sda_lvl = tick.ack_to_send;
        end
        if (cur_op != i2cms_pkg::OP_NONE) begin
            res.busy_res = 1'b1;
            case (cur_op)
                i2cms_pkg::OP_START: begin
                    seq_len = STEPS_START;
                    case (cur_step)
                        5'd0:    sda_lvl = 1'b1;
                        5'd1:    scl_lvl = 1'b1;
                        5'd2:    sda_lvl = 1'b0;
                        default: scl_lvl = 1'b0;
                    endcase
                end
                i2cms_pkg::OP_STOP: begin
                    seq_len = STEPS_STOP;
                    case (cur_step)
                        5'd0:    sda_lvl = 1'b0;
                        5'd1:    scl_lvl = 1'b1;
                        default: sda_lvl = 1'b1;
                    endcase
                end
                i2cms_pkg::OP_WRITE: begin
                    seq_len = STEPS_WRITE;
                    if (cur_step < 5'(BYTE_BITS * 3)) begin
                        case (cur_step % 3)
                            0: sda_lvl = tx_sr[7];
                            1: scl_lvl = 1'b1;
                            default: begin
                                scl_lvl = 1'b0;
                                tx_sr   = tx_sr << 1;
                            end
                        endcase
                    end else if (cur_step == 5'(BYTE_BITS * 3)) begin
                        scl_lvl = 1'b1;     // SCL high for the ack bit, ack ignored
                    end else begin
                        scl_lvl = 1'b0;
                    end
                end
                i2cms_pkg::OP_READ: begin
                    seq_len = STEPS_READ;
                    if (cur_step == 5'd0) begin
                        sda_lvl = 1'b1;
                    end else if (cur_step[0]) begin
                        scl_lvl = 1'b1;
                        bit_idx = (int'(cur_step) - 1) >> 1;
                        if (tick.sda_level && bit_idx < BYTE_BITS)
                            rx_sr[3'(BYTE_BITS - 1 - bit_idx)] = 1'b1;
                    end else begin
                        scl_lvl = 1'b0;
                    end
                end
                i2cms_pkg::OP_SACK: begin
                    seq_len = STEPS_ACK;
                    if (cur_step == 5'd1) scl_lvl = 1'b1;
                    else if (cur_step == 5'd2) scl_lvl = 1'b0;
                end
                i2cms_pkg::OP_RACK: begin
                    seq_len = STEPS_ACK;
                    case (cur_step)
                        5'd0: sda_lvl = 1'b1;
                        5'd1: begin
                            scl_lvl = 1'b1;
                            ack_lat = tick.sda_level;
                        end
                        default: scl_lvl = 1'b0;
                    endcase
                end
                default: ;
            endcase
            cur_step = cur_step + 5'd1;
            if (cur_step >= seq_len) begin
                res.done_res = 1'b1;
                cur_op       = i2cms_pkg::OP_NONE;
                cur_step     = '0;
            end
        end
        res.scl_drive = scl_lvl;
        res.sda_drive = sda_lvl;
        res.rx_byte   = rx_sr;
        res.ack_seen  = ack_lat;
        return res;
    endfunction

    function automatic logic sda_sample(input int mode);
        if (mode == SDA_LOW) return 1'b0;
        if (mode == SDA_HIGH) return 1'b1;
        return 1'($urandom_range(0, 1));
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one tick transaction, with an optional idle burst first.
    // The prediction is queued at the edge that accepts the transaction.
    // ------------------------------------------------------------------------
    task automatic send_tick(input i2cms_pkg::t_in tick);
        if (allow_gaps && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= tick;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        expected_pins.push_back(predict_tick(tick));
        ticks_sent++;
    endtask

    // Issue a code, then keep ticking until the sequence ends. Ticks that land
    // while busy sometimes carry a command of their own, which must be ignored.
    task automatic issue_command(input logic [2:0] code, input logic [7:0] data,
                                 input logic ack_bit, input int sda_mode);
        i2cms_pkg::t_in tick;
        tick.func        = code;
        tick.tx_byte     = data;
        tick.ack_to_send = ack_bit;
        tick.sda_level   = sda_sample(sda_mode);
        send_tick(tick);
        while (cur_op != i2cms_pkg::OP_NONE) begin
            tick.func        = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                                           : i2cms_pkg::OP_NONE;
            tick.tx_byte     = 8'($urandom);
            tick.ack_to_send = 1'($urandom_range(0, 1));
            tick.sda_level   = sda_sample(sda_mode);
            send_tick(tick);
        end
    endtask

    // A well-formed transfer: start, address, ack, data bytes with acks, usually a stop
    task automatic run_transfer();
        int   n_bytes;
        logic is_read;
        n_bytes = $urandom_range(1, 3);
        is_read = 1'($urandom_range(0, 1));
        issue_command(i2cms_pkg::OP_START, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND);
        issue_command(i2cms_pkg::OP_WRITE, {7'($urandom), is_read},
                      1'($urandom_range(0, 1)), SDA_RAND);
        issue_command(i2cms_pkg::OP_RACK, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND);
        for (int i = 0; i < n_bytes; i++) begin
            if (is_read) begin
                issue_command(i2cms_pkg::OP_READ, 8'($urandom),
                              1'($urandom_range(0, 1)), SDA_RAND);
                // nack the last byte
                issue_command(i2cms_pkg::OP_SACK, 8'($urandom), (i == n_bytes - 1), SDA_RAND);
            end else begin
                issue_command(i2cms_pkg::OP_WRITE, 8'($urandom),
                              1'($urandom_range(0, 1)), SDA_RAND);
                issue_command(i2cms_pkg::OP_RACK, 8'($urandom),
                              1'($urandom_range(0, 1)), SDA_RAND);
            end
        end
        // now and then leave the bus for a repeated start
        if ($urandom_range(0, 7) != 0)
            issue_command(i2cms_pkg::OP_STOP, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_idle_codes();
        issue_command(i2cms_pkg::OP_NONE, 8'h00, 1'b0, SDA_LOW);
        issue_command(i2cms_pkg::OP_NONE, 8'hFF, 1'b1, SDA_HIGH);
        issue_command(CODE_UNUSED, 8'hFF, 1'b1, SDA_HIGH);
        issue_command(CODE_UNUSED, 8'h00, 1'b0, SDA_LOW);
    endtask

    task automatic test_each_command();
        issue_command(i2cms_pkg::OP_START, 8'h00, 1'b1, SDA_RAND);
        issue_command(i2cms_pkg::OP_WRITE, 8'h00, 1'b1, SDA_RAND);
        issue_command(i2cms_pkg::OP_RACK, 8'h00, 1'b1, SDA_LOW);
        issue_command(i2cms_pkg::OP_WRITE, 8'hFF, 1'b0, SDA_RAND);
        issue_command(i2cms_pkg::OP_RACK, 8'hFF, 1'b0, SDA_HIGH);
        issue_command(i2cms_pkg::OP_READ, 8'h00, 1'b0, SDA_HIGH);
        issue_command(i2cms_pkg::OP_SACK, 8'h00, 1'b0, SDA_RAND);
        issue_command(i2cms_pkg::OP_READ, 8'hFF, 1'b1, SDA_LOW);
        issue_command(i2cms_pkg::OP_SACK, 8'hFF, 1'b1, SDA_RAND);
        issue_command(i2cms_pkg::OP_READ, 8'h5A, 1'b0, SDA_RAND);
        issue_command(i2cms_pkg::OP_STOP, 8'hA5, 1'b0, SDA_RAND);
        issue_command(i2cms_pkg::OP_STOP, 8'h00, 1'b1, SDA_RAND);
    endtask

    task automatic test_random_transfers();
        while (ticks_sent < ITEM_TARGET - ITEM_RESERVE) begin
            allow_gaps <= ($urandom_range(0, 3) != 0);
            // stray codes between transfers, some of them start a sequence
            if ($urandom_range(0, 2) == 0)
                issue_command(3'($urandom_range(0, 7)), 8'($urandom),
                              1'($urandom_range(0, 1)), SDA_RAND);
            run_transfer();
        end
    endtask

    task automatic test_full_rate();
        allow_gaps <= 1'b0;
        repeat (2) run_transfer();
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stall bursts and the in-order result check
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (allow_gaps && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        i2cms_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_pins.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result %p", o_out_data);
            end else begin
                want = expected_pins.pop_front();
                if (o_out_data.scl_drive !== want.scl_drive ||
                    o_out_data.sda_drive !== want.sda_drive ||
                    o_out_data.busy_res  !== want.busy_res  ||
                    o_out_data.done_res  !== want.done_res  ||
                    o_out_data.rx_byte   !== want.rx_byte   ||
                    o_out_data.ack_seen  !== want.ack_seen) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: expected scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                                 want.scl_drive, want.sda_drive, want.busy_res,
                                 want.done_res, want.rx_byte, want.ack_seen,
                                 "\n          actual   scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                                 o_out_data.scl_drive, o_out_data.sda_drive,
                                 o_out_data.busy_res, o_out_data.done_res,
                                 o_out_data.rx_byte, o_out_data.ack_seen);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_codes();
        test_each_command();
        test_random_transfers();
        test_full_rate();
        i_in_valid <= 1'b0;
        while (expected_pins.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### files.f
sv/i2cms_pkg.sv
sv/i2cms_step.sv
sv/i2c_master_bit_sequencer_core.sv
tb/testbench.sv
